FILE: design/magic_length_frame_deframer_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the magic length frame deframer
// Shared property wrappers clocked on clk_i; MLFD_ASSERT is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// check a property on every clock edge outside reset
`define MLFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define MLFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/mlfd_pkg.sv
// ----------------------------------------------------------------------------
// mlfd_pkg
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfd_pkg;

  localparam logic [1:0] PhHunt = 2'd0;
  localparam logic [1:0] PhLen  = 2'd1;
  localparam logic [1:0] PhData = 2'd2;

  localparam logic [2:0] LenLastIdx = 3'd7;

  localparam logic [7:0] SyncB0 = 8'h43;
  localparam logic [7:0] SyncB1 = 8'h41;
  localparam logic [7:0] SyncB2 = 8'h53;
  localparam logic [7:0] SyncB3 = 8'h4C;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEmpty   = 1'b1;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = SyncB0;
      2'd1:    b = SyncB1;
      2'd2:    b = SyncB2;
      2'd3:    b = SyncB3;
      default: b = SyncB0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: design/magic_length_frame_deframer_unit.sv
// A byte accepted into the input register is parsed when it advances, which
// loads the result register if the byte yields a result, making it valid on the
// master side; a master-side stall can hold the byte in the input register.
// Throughput: one byte per cycle while the master side does not stall, set by
// the single parse stage between the input register and the result register.
// Reset: asynchronous, active low; sync hunt, both register stages empty.
// ----------------------------------------------------------------------------
// magic_length_frame_deframer_unit
// Sync word hunt, 64-bit big-endian length and payload pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

`include "magic_length_frame_deframer_unit_defines.svh"

module magic_length_frame_deframer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] payload_byte
  output logic            m_axis_tuser_o,   // [0] kind
  output logic            m_axis_tlast_o    // last_of_message
);

  logic           in_valid_q;
  logic [7:0]     in_byte_q;
  logic           out_free;
  logic           advance;
  logic           s_accept;
  mlfd_pkg::res_t res;

  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;
  assign advance         = in_valid_q && (!res.valid || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  mlfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  mlfd_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance && res.valid),
    .res_i           (res),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  `MLFD_ASSERT(a_empty_is_last, (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o,
               "empty completion without last flag")
  `MLFD_ASSERT(a_no_overwrite, (in_valid_q && res.valid && m_axis_tvalid_o && !m_axis_tready_i)
               |=> ($stable(m_axis_tdata_o) && in_valid_q),
               "stalled result overwritten or request lost")

endmodule

`default_nettype wire

FILE: design/mlfd_parser.sv
// ----------------------------------------------------------------------------
// mlfd_parser
// Sync hunt, length gather and payload count for one registered byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "magic_length_frame_deframer_unit_defines.svh"

module mlfd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire logic [7:0]    byte_i,
  output mlfd_pkg::res_t     res_o
);

  logic [1:0]  phase_q, phase_d;
  logic [1:0]  match_q, match_d;
  logic [2:0]  lcnt_q, lcnt_d;
  logic [63:0] shift_q, shift_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] shift_nx;
  logic        last_w;

  assign shift_nx = {shift_q[55:0], byte_i};
  assign last_w   = (rem_q <= 64'd1);

  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    lcnt_d  = lcnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    res_o   = '0;
    case (phase_q)
      mlfd_pkg::PhLen: begin
        shift_d = shift_nx;
        if (lcnt_q == mlfd_pkg::LenLastIdx) begin
          lcnt_d = 3'd0;
          if (shift_nx == 64'd0) begin
            phase_d    = mlfd_pkg::PhHunt;
            match_d    = 2'd0;
            res_o.valid = 1'b1;
            res_o.kind  = mlfd_pkg::KindEmpty;
            res_o.last  = 1'b1;
          end else begin
            rem_d   = shift_nx;
            shift_d = 64'd0;
            phase_d = mlfd_pkg::PhData;
          end
        end else begin
          lcnt_d = lcnt_q + 3'd1;
        end
      end
      mlfd_pkg::PhData: begin
        res_o.valid = 1'b1;
        res_o.kind  = mlfd_pkg::KindPayload;
        res_o.data  = byte_i;
        res_o.last  = last_w;
        if (last_w) begin
          rem_d   = 64'd0;
          phase_d = mlfd_pkg::PhHunt;
          match_d = 2'd0;
        end else begin
          rem_d = rem_q - 64'd1;
        end
      end
      default: begin
        phase_d = mlfd_pkg::PhHunt;
        if (byte_i == mlfd_pkg::sync_byte(match_q)) begin
          if (match_q == 2'd3) begin
            match_d = 2'd0;
            lcnt_d  = 3'd0;
            shift_d = 64'd0;
            phase_d = mlfd_pkg::PhLen;
          end else begin
            match_d = match_q + 2'd1;
          end
        end else begin
          match_d = (byte_i == mlfd_pkg::SyncB0) ? 2'd1 : 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mlfd_pkg::PhHunt;
      match_q <= 2'd0;
      lcnt_q  <= 3'd0;
      shift_q <= 64'd0;
      rem_q   <= 64'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      match_q <= match_d;
      lcnt_q  <= lcnt_d;
      shift_q <= shift_d;
      rem_q   <= rem_d;
    end
  end

  `MLFD_ASSERT(a_phase_legal, phase_q != 2'd3, "unused phase reached")
  `MLFD_ASSERT(a_len_no_match, (phase_q == mlfd_pkg::PhLen) |-> (match_q == 2'd0),
               "sync match count left set while gathering length")
  `MLFD_ASSERT(a_data_nonzero, (phase_q == mlfd_pkg::PhData) |-> (rem_q != 64'd0),
               "payload phase with nothing remaining")

endmodule

`default_nettype wire

FILE: design/mlfd_out_reg.sv
// ----------------------------------------------------------------------------
// mlfd_out_reg
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfd_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire mlfd_pkg::res_t res_i,
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o,
  output logic                m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       kind_q;
  logic       last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i.data;
      kind_q <= res_i.kind;
      last_q <= res_i.last;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = last_q;

endmodule

`default_nettype wire
